// File: hdl/packbits_pixel_decoder_assert.svh
// Assertion macros shared by the checker of the PackBits pixel decoder.
`ifndef PACKBITS_PIXEL_DECODER_ASSERT_SVH
`define PACKBITS_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define PPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packbits_pixel_decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packbits_pixel_decoder: next-cycle check failed");

`endif

// File: hdl/ppd_pkg.sv
// Shared types and constants of the PackBits pixel decoder.
package ppd_pkg;

  // Request carried by the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_req_t;

  // Request carried by the output channel.
  typedef struct packed {
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [1:0] pixel_count;
    logic       last_of_run;
    logic [1:0] status;
  } out_req_t;

  // One classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] npix;
    logic [1:0] status;
  } job_t;

  // Decoder status codes.
  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_RAN_OUT  = 2'd3;

  // PackBits header byte that ends the body.
  localparam logic [7:0] HDR_END = 8'd128;

  // Configuration register indexes.
  localparam logic [0:0] REG_TOTAL = 1'b0;
  localparam logic [0:0] REG_MODE  = 1'b1;

  // Depth of the job queue between the two halves.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

endpackage

// File: hdl/ppd_front.sv
// Front part: configuration registers, PackBits parsing and pixel accounting.
module ppd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppd_pkg::in_req_t in_req_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ppd_pkg::job_t    q_job_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_RUN,
    PH_DONE
  } phase_e;

  logic [31:0] total_q, total_d;
  logic        mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  lit_q, lit_d;
  logic [7:0]  run_q, run_d;
  logic [31:0] done_q, done_d;
  logic [1:0]  status_q, status_d;

  logic        accept;
  logic [32:0] diff;
  logic [31:0] rem;
  logic        reached;
  logic        rem_is_one;
  logic        run_over;
  logic [7:0]  lit_dec;
  logic [7:0]  npix;
  logic        eod;
  logic [7:0]  byte_in;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_stall_o = q_full_i;
  assign eod        = in_req_i.end_of_data;
  assign byte_in    = in_req_i.data_byte;

  // The borrow of total minus done, or a zero remainder, tells whether the total is already met.
  assign diff       = {1'b0, total_q} - {1'b0, done_q};
  assign rem        = diff[31:0];
  assign reached    = diff[32] | (rem == 32'd0);
  assign rem_is_one = (rem == 32'd1);
  assign run_over   = ({24'd0, run_q} > rem);
  assign lit_dec    = lit_q - 8'd1;

  always_comb begin
    total_d  = total_q;
    mode_d   = mode_q;
    phase_d  = phase_q;
    lit_d    = lit_q;
    run_d    = run_q;
    done_d   = done_q;
    status_d = status_q;
    npix     = 8'd0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ppd_pkg::REG_TOTAL: total_d = cfg_data_i;
        ppd_pkg::REG_MODE:  mode_d  = cfg_data_i[0];
        default: ;
      endcase
    end

    if (status_q == ppd_pkg::ST_BUSY) begin
      if (reached) begin
        status_d = ppd_pkg::ST_COMPLETE;
        phase_d  = PH_DONE;
      end else begin
        if (!mode_q) begin
          // Raw byte: one pixel, pending PackBits counts are left alone.
          npix   = 8'd1;
          done_d = done_q + 32'd1;
          if (rem_is_one) begin
            status_d = eod ? ppd_pkg::ST_COMPLETE : ppd_pkg::ST_MISMATCH;
          end else if (eod) begin
            status_d = ppd_pkg::ST_MISMATCH;
          end
        end else begin
          case (phase_q)
            PH_LITERAL: begin
              npix   = 8'd1;
              done_d = done_q + 32'd1;
              lit_d  = lit_dec;
              if (lit_dec == 8'd0) begin
                phase_d = PH_HEADER;
              end
              if (rem_is_one) begin
                status_d = (lit_dec != 8'd0) ? ppd_pkg::ST_MISMATCH : ppd_pkg::ST_COMPLETE;
              end
            end
            PH_RUN: begin
              // A run that passes the total is clipped there.
              if (run_over) begin
                npix     = rem[7:0];
                done_d   = total_q;
                status_d = ppd_pkg::ST_MISMATCH;
              end else begin
                npix   = run_q;
                done_d = done_q + {24'd0, run_q};
                if (rem == {24'd0, run_q}) begin
                  status_d = ppd_pkg::ST_COMPLETE;
                end
              end
              run_d   = 8'd0;
              phase_d = PH_HEADER;
            end
            PH_HEADER: begin
              if (byte_in < ppd_pkg::HDR_END) begin
                lit_d   = byte_in + 8'd1;
                phase_d = PH_LITERAL;
              end else if (byte_in > ppd_pkg::HDR_END) begin
                // 257 minus the header, kept in eight bits.
                run_d   = (8'd0 - byte_in) + 8'd1;
                phase_d = PH_RUN;
              end else begin
                status_d = ppd_pkg::ST_MISMATCH;
              end
            end
            default: ;
          endcase
        end
        if (status_d == ppd_pkg::ST_BUSY && eod) begin
          status_d = ppd_pkg::ST_RAN_OUT;
        end
        if (status_d != ppd_pkg::ST_BUSY) begin
          phase_d = PH_DONE;
          lit_d   = 8'd0;
          run_d   = 8'd0;
        end
      end
    end
  end

  assign q_push_o          = accept;
  assign q_job_o.data_byte = byte_in;
  assign q_job_o.npix      = npix;
  assign q_job_o.status    = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= 32'd0;
      mode_q   <= 1'b1;
      phase_q  <= PH_HEADER;
      lit_q    <= 8'd0;
      run_q    <= 8'd0;
      done_q   <= 32'd0;
      status_q <= ppd_pkg::ST_BUSY;
    end else begin
      total_q <= total_d;
      mode_q  <= mode_d;
      if (accept) begin
        phase_q  <= phase_d;
        lit_q    <= lit_d;
        run_q    <= run_d;
        done_q   <= done_d;
        status_q <= status_d;
      end
    end
  end

endmodule

// File: hdl/ppd_queue.sv
// Short job queue that decouples the parser from the pixel expander.
module ppd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppd_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ppd_pkg::job_t head_o
);

  ppd_pkg::job_t                     entry_q [ppd_pkg::QUEUE_DEPTH];
  logic [ppd_pkg::QPTR_W-1:0]        wr_ptr_q;
  logic [ppd_pkg::QPTR_W-1:0]        rd_ptr_q;
  logic [ppd_pkg::QCNT_W-1:0]        count_q;
  logic [ppd_pkg::QCNT_W-1:0]        count_d;

  assign full_o  = (count_q == ppd_pkg::QCNT_W'(ppd_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + ppd_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - ppd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + ppd_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + ppd_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hdl/ppd_back.sv
// Back part: expands each job into result items of up to two pixels.
module ppd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ppd_pkg::job_t     q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ppd_pkg::out_req_t out_req_o
);

  logic              busy_q;
  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic [7:0]        left_q;
  logic [1:0]        status_q;
  ppd_pkg::out_req_t out_q;

  logic              out_free;
  logic              emit;
  logic              last;
  logic              load;
  logic [1:0]        cnt;
  ppd_pkg::out_req_t item;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign emit     = busy_q & out_free;
  assign cnt      = (left_q >= 8'd2) ? 2'd2 : left_q[1:0];
  assign last     = (left_q <= 8'd2);
  assign load     = ~q_empty_i & (~busy_q | (emit & last));
  assign q_pop_o  = load;

  always_comb begin
    item.pixel_a     = (cnt != 2'd0) ? byte_q : 8'd0;
    item.pixel_b     = (cnt == 2'd2) ? byte_q : 8'd0;
    item.pixel_count = cnt;
    item.last_of_run = last;
    item.status      = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit | (out_valid_q & out_stall_i);
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= q_job_i.data_byte;
      left_q   <= q_job_i.npix;
      status_q <= q_job_i.status;
    end else if (emit) begin
      left_q <= left_q - {6'd0, cnt};
    end
    if (emit) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// File: hdl/packbits_pixel_decoder.sv
// Top level of the PackBits pixel decoder.
//
// Body bytes enter on the input channel, one per request, each with a flag
// that marks the last byte of the body. Decoded pixels leave on the output
// channel, up to two per request, together with a pixel count, a flag on the
// last request caused by each byte and the decoder status. Every byte gives
// at least one output request, a byte that makes no pixel gives an empty one.
// The configuration port sets the expected pixel total and the mode (PackBits
// or raw); the user must write it only while the decoder is idle, which the
// block does not enforce. A byte is parsed in the cycle it is accepted; its
// job passes the queue, the expander and the output register. The expander
// issues one output request a cycle unless the output stalls. A byte gives
// max(1, ceil(pixels / 2)) requests, up to 64 for a run of 128 pixels. The
// two-entry job queue lets the parser take further bytes during a run. Reset
// clears the status to busy, the pixel count to zero, the total to zero and
// selects PackBits mode. When the receiver stalls, the output request is held,
// the expander and then the queue fill, and the input stalls.
module packbits_pixel_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ppd_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ppd_pkg::out_req_t out_req_o
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  ppd_pkg::job_t push_job;
  ppd_pkg::job_t head_job;

  // Parser: keeps the PackBits state and the pixel tally.
  ppd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_job_o    (push_job)
  );

  // Jobs waiting between parser and expander.
  ppd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  // Expander: turns each job into pixel pairs behind an output register.
  ppd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_job_i     (head_job),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: hdl/ppd_chk.sv
// Port-level checker of the PackBits pixel decoder and its bind.
`include "packbits_pixel_decoder_assert.svh"

module ppd_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ppd_pkg::out_req_t out_req_o
);

  // A pixel count of three never appears.
  `PPD_ASSERT_IMPL(a_count_range, clk_i, rst_ni, out_valid_o, out_req_o.pixel_count != 2'd3)

  // Slots without a pixel read as zero.
  `PPD_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o && out_req_o.pixel_count != 2'd2, out_req_o.pixel_b == 8'd0 && (out_req_o.pixel_count != 2'd0 || out_req_o.pixel_a == 8'd0))

  // Only the final request of a byte may carry fewer than two pixels.
  `PPD_ASSERT_IMPL(a_full_until_last, clk_i, rst_ni, out_valid_o && !out_req_o.last_of_run, out_req_o.pixel_count == 2'd2)

  // A stalled output request is held.
  `PPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o))

endmodule

bind packbits_pixel_decoder ppd_chk u_ppd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
